// ===== rtl/assert_macros.svh =====
// Assertion macros for the scheduler RTL.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/pss_pkg.sv =====
// Shared types and codes for the priority slice scheduler.
// No dependencies.
package pss_pkg;
  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;
  localparam logic [1:0] FUNC_TERM   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic        run;
    logic [31:0] rtime;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_RI,   // read entry i
    S_SORT_RJ,   // read entry j
    S_SORT_CMP,  // compare, maybe swap
    S_SORT_WB,   // write the row winner back to i
    S_GRANT_RD,
    S_GRANT_CHK,
    S_END_RD,
    S_END_WR,
    S_TERM_RD,
    S_TERM_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_OUT
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

// ===== rtl/pss_table_ram.sv =====
// Task table memory: one write port, one registered read port.
// Depends on pss_pkg for the entry type.
module pss_table_ram #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pss_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output pss_pkg::entry_t  rdata
);
  pss_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/priority_slice_scheduler.sv =====
// Top level of the priority slice scheduler: sequencer around one table memory.
// Depends on pss_pkg, pss_table_ram and assert_macros.svh.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/ready   | func, task_id, task_priority, elapsed_ms
//  out     | output    | out_valid/ready  | status, out_id, run_total, last
//  cfg     | input     | cfg_valid/ready  | cfg_data (max_grants)
//
// Slice start first runs an exchange sort on the table, then scans the
// entries and sends the grants as out beats; every step is bound by the
// single read and write port.
// Reset clears the entry count; each entry is written whole by its submit,
// so its running flag starts at zero. A stalled out beat holds the
// sequencer; no new item or cfg write is taken until the last beat leaves.
`include "assert_macros.svh"
module priority_slice_scheduler #(
  parameter int TABLE_DEPTH = 64,
  parameter int GRANT_LIMIT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_task_id,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_out_id,
  output logic [31:0] out_run_total,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int GW = $clog2(GRANT_LIMIT + 1);

  pss_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [GW-1:0] ngrant_r, ngrant_nxt;
  logic [GW-1:0] grant_limit;
  logic [4:0]    maxg_r;
  logic [15:0]   tid_r;
  logic [15:0]   el_r;
  pss_pkg::entry_t ei_r, ei_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [15:0]   oid_r, oid_nxt;
  logic [31:0]   tot_r, tot_nxt;
  logic          last_r, last_nxt;
  logic [15:0]   pend_r, pend_nxt;
  pss_pkg::state_t ret_r, ret_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  pss_pkg::entry_t wdata, rdata;

  pss_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == pss_pkg::S_IDLE);
  assign cfg_ready = (state_r == pss_pkg::S_IDLE);
  assign out_valid = (state_r == pss_pkg::S_OUT);
  assign out_status    = st_r;
  assign out_out_id    = oid_r;
  assign out_run_total = tot_r;
  assign out_last      = last_r;

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxg_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      maxg_r <= cfg_data;
    end
  end
  // cap the grant count
  always_comb begin
    if ({27'd0, maxg_r} > GRANT_LIMIT) grant_limit = GW'(GRANT_LIMIT);
    else grant_limit = GW'(maxg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pss_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tid_r  <= in_task_id;
      el_r   <= in_elapsed_ms;
    end
    i_r <= i_nxt; j_r <= j_nxt; ngrant_r <= ngrant_nxt; ei_r <= ei_nxt;
    st_r <= st_nxt; oid_r <= oid_nxt; tot_r <= tot_nxt; last_r <= last_nxt;
    ret_r <= ret_nxt; pend_r <= pend_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            pss_pkg::FUNC_SUBMIT: state_nxt = pss_pkg::S_OUT;
            pss_pkg::FUNC_START:  state_nxt = pss_pkg::S_SORT_RI;
            pss_pkg::FUNC_END:    state_nxt = pss_pkg::S_END_RD;
            default:              state_nxt = pss_pkg::S_TERM_RD;
          endcase
        end
      end
      pss_pkg::S_SORT_RI: begin
        if (i_r + CW'(1) >= count_r) state_nxt = pss_pkg::S_GRANT_RD;
        else state_nxt = pss_pkg::S_SORT_RJ;
      end
      pss_pkg::S_SORT_RJ:  state_nxt = pss_pkg::S_SORT_CMP;
      pss_pkg::S_SORT_CMP: begin
        if (j_r + CW'(1) >= count_r) state_nxt = pss_pkg::S_SORT_WB;
        else state_nxt = pss_pkg::S_SORT_RJ;
      end
      pss_pkg::S_SORT_WB:  state_nxt = pss_pkg::S_SORT_RI;
      pss_pkg::S_GRANT_RD: begin
        if (i_r >= count_r || ngrant_r >= grant_limit) state_nxt = pss_pkg::S_OUT;
        else state_nxt = pss_pkg::S_GRANT_CHK;
      end
      pss_pkg::S_GRANT_CHK: begin
        if (rdata.run || ngrant_r == '0) state_nxt = pss_pkg::S_GRANT_RD;
        else state_nxt = pss_pkg::S_OUT;
      end
      pss_pkg::S_END_RD: begin
        state_nxt = (i_r >= count_r) ? pss_pkg::S_IDLE : pss_pkg::S_END_WR;
      end
      pss_pkg::S_END_WR: state_nxt = pss_pkg::S_END_RD;
      pss_pkg::S_TERM_RD: begin
        state_nxt = (i_r >= count_r) ? pss_pkg::S_OUT : pss_pkg::S_TERM_CHK;
      end
      pss_pkg::S_TERM_CHK: begin
        state_nxt = (rdata.id == tid_r) ? pss_pkg::S_SHIFT_RD : pss_pkg::S_TERM_RD;
      end
      pss_pkg::S_SHIFT_RD: begin
        state_nxt = (i_r + CW'(1) >= count_r) ? pss_pkg::S_OUT : pss_pkg::S_SHIFT_WR;
      end
      pss_pkg::S_SHIFT_WR: state_nxt = pss_pkg::S_SHIFT_RD;
      pss_pkg::S_OUT: begin
        if (out_ready) state_nxt = ret_r;
      end
      default: state_nxt = pss_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt = count_r;
    i_nxt = i_r; j_nxt = j_r; ngrant_nxt = ngrant_r; ei_nxt = ei_r;
    st_nxt = st_r; oid_nxt = oid_r; tot_nxt = tot_r; last_nxt = last_r;
    ret_nxt = ret_r; pend_nxt = pend_r;
    we = 1'b0; waddr = i_r[AW-1:0]; wdata = rdata; raddr = i_r[AW-1:0];
    unique case (state_r)
      pss_pkg::S_IDLE: begin
        i_nxt = '0; ngrant_nxt = '0; ret_nxt = pss_pkg::S_IDLE;
        tot_nxt = '0; last_nxt = 1'b1; oid_nxt = in_task_id;
        if (accept && in_func == pss_pkg::FUNC_SUBMIT) begin
          if (count_r >= CW'(TABLE_DEPTH)) begin
            st_nxt = pss_pkg::ST_FULL;
          end else begin
            st_nxt = pss_pkg::ST_OK;
            we = 1'b1; waddr = count_r[AW-1:0];
            wdata = '{id: in_task_id, prio: in_task_priority, run: 1'b0, rtime: '0};
            count_nxt = count_r + CW'(1);
          end
        end
      end
      pss_pkg::S_SORT_RI: begin
        raddr = i_r[AW-1:0];
        j_nxt = i_r + CW'(1);
        if (i_r + CW'(1) >= count_r) i_nxt = '0;
      end
      pss_pkg::S_SORT_RJ: begin
        if (j_r == i_r + CW'(1)) ei_nxt = rdata;
        raddr = j_r[AW-1:0];
      end
      pss_pkg::S_SORT_CMP: begin
        // exchange: j takes i's entry, i keeps the larger
        if (ei_r.prio < rdata.prio) begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = ei_r;
          ei_nxt = rdata;
        end
        j_nxt = j_r + CW'(1);
      end
      pss_pkg::S_SORT_WB: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = ei_r;
        i_nxt = i_r + CW'(1);
      end
      pss_pkg::S_GRANT_RD: begin
        raddr = i_r[AW-1:0];
        if (i_r >= count_r || ngrant_r >= grant_limit) begin
          // flush the held grant as the final beat, or report none
          if (ngrant_r == '0) begin
            st_nxt = pss_pkg::ST_NONE; oid_nxt = '0;
          end else begin
            st_nxt = pss_pkg::ST_OK; oid_nxt = pend_r;
          end
          tot_nxt = '0; last_nxt = 1'b1; ret_nxt = pss_pkg::S_IDLE;
        end
      end
      pss_pkg::S_GRANT_CHK: begin
        i_nxt = i_r + CW'(1);
        if (!rdata.run) begin
          we = 1'b1; waddr = i_r[AW-1:0];
          wdata = rdata; wdata.run = 1'b1;
          ngrant_nxt = ngrant_r + GW'(1);
          // hold the new grant until it is known whether it is the final beat
          pend_nxt = rdata.id;
          st_nxt = pss_pkg::ST_OK; oid_nxt = pend_r; tot_nxt = '0;
          last_nxt = 1'b0; ret_nxt = pss_pkg::S_GRANT_RD;
        end
      end
      pss_pkg::S_END_RD: raddr = i_r[AW-1:0];
      pss_pkg::S_END_WR: begin
        if (rdata.run) begin
          we = 1'b1; waddr = i_r[AW-1:0]; wdata = rdata;
          wdata.run = 1'b0; wdata.rtime = pss_pkg::sat_add(rdata.rtime, el_r);
        end
        i_nxt = i_r + CW'(1);
      end
      pss_pkg::S_TERM_RD: begin
        raddr = i_r[AW-1:0];
        if (i_r >= count_r) begin
          st_nxt = pss_pkg::ST_NOT_FOUND; oid_nxt = tid_r; tot_nxt = '0;
        end
      end
      pss_pkg::S_TERM_CHK: begin
        if (rdata.id == tid_r) begin
          st_nxt = pss_pkg::ST_OK; oid_nxt = tid_r;
          tot_nxt = rdata.run ? pss_pkg::sat_add(rdata.rtime, el_r) : rdata.rtime;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      pss_pkg::S_SHIFT_RD: begin
        raddr = i_r[AW-1:0] + AW'(1);
        if (i_r + CW'(1) >= count_r) count_nxt = count_r - CW'(1);
      end
      pss_pkg::S_SHIFT_WR: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = rdata;
        i_nxt = i_r + CW'(1);
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_idle_no_accept, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_out_id))
endmodule
